[sv/indexed_list_store_macros.svh]
// assertion macros for the indexed list store
`ifndef INDEXED_LIST_STORE_MACROS_SVH
`define INDEXED_LIST_STORE_MACROS_SVH

`ifndef SYNTHESIS

// concurrent check on an explicit clock and active-low reset
`define ILS_ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// concurrent check on the block clock and reset
`define ILS_ASSERT(label, prop, msg) \
  `ILS_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`else

`define ILS_ASSERT_CLK(label, clk, rstn, prop, msg)

`define ILS_ASSERT(label, prop, msg)

`endif

`endif

[sv/ils_pkg.sv]
// shared types and constants of the indexed list store
`default_nettype none

package ils_pkg;

  localparam int DepthDef    = 64;
  localparam int WordBitsDef = 32;
  localparam int FuncBits    = 3;
  localparam int StatusBits  = 2;

  typedef enum logic [FuncBits-1:0] {
    FN_ADD_FRONT    = 3'd0,
    FN_ADD_BACK     = 3'd1,
    FN_INSERT_AT    = 3'd2,
    FN_REMOVE_FRONT = 3'd3,
    FN_REMOVE_BACK  = 3'd4,
    FN_REMOVE_AT    = 3'd5,
    FN_GET_AT       = 3'd6,
    FN_FIND         = 3'd7
  } ils_func_e;

  typedef enum logic [StatusBits-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } ils_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_UP,
    S_INS_LAST,
    S_RM_HEAD,
    S_SHIFT_DN,
    S_GET_WAIT,
    S_SCAN
  } ils_state_e;

  // sequencer status seen by the top level
  typedef struct packed {
    logic busy;
    logic mem_wr;
  } ils_ctrl_t;

endpackage

`default_nettype wire

[sv/indexed_list_store.sv]
// top level of the indexed list store: bounded ordered list of signed words
//
// command channel: a transaction is taken at a rising edge with start high
// and busy low. func selects add front, add back, insert at, remove front,
// remove back, remove at, get at or find; value and position go with it.
// result channel: done_o is high for exactly one cycle with result_value_o,
// result_position_o, status_o and length_o; the receiver cannot stall it,
// so the result must be taken in that cycle.
// commands that end without a shift or a ram read (full, empty, bad
// position, append at the back) give their result in the cycle after
// acceptance, busy never raised. get at reads the entry and returns it;
// find reads up from position 0 and stops at the first match or the tail;
// an insert at p moves entries from the tail down to p up one place, then
// writes the new word; a removal reads the word, then pulls the rest down.
// the list ram has one write and one registered read port; a shift reads
// one entry while writing another, never the same one.
// reset clears the length and the sequencer only; list words are never
// read before they are written, so the ram needs no clearing pass.
`default_nettype none

`include "indexed_list_store_macros.svh"

module indexed_list_store #(
  parameter int DEPTH     = ils_pkg::DepthDef,
  parameter int WORD_BITS = ils_pkg::WordBitsDef,
  localparam int AddrBits = $clog2(DEPTH),
  localparam int PosBits  = $clog2(DEPTH + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [ils_pkg::FuncBits-1:0]   func_i,
  input  logic [WORD_BITS-1:0]           value_i,
  input  logic [PosBits-1:0]             position_i,
  output logic                           done_o,
  output logic [WORD_BITS-1:0]           result_value_o,
  output logic [PosBits-1:0]             result_position_o,
  output logic [ils_pkg::StatusBits-1:0] status_o,
  output logic [PosBits-1:0]             length_o
);

  import ils_pkg::*;

  ils_ctrl_t            ctrl;
  logic                 mem_we, mem_re;
  logic [AddrBits-1:0]  mem_waddr, mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata, mem_rdata;

  // sequencer: command decode, shift and scan loops, result registers
  ils_seq #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_seq (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start),
    .func_i            (func_i),
    .value_i           (value_i),
    .position_i        (position_i),
    .ctrl_o            (ctrl),
    .done_o            (done_o),
    .result_value_o    (result_value_o),
    .result_position_o (result_position_o),
    .status_o          (status_o),
    .length_o          (length_o),
    .mem_we_o          (mem_we),
    .mem_waddr_o       (mem_waddr),
    .mem_wdata_o       (mem_wdata),
    .mem_re_o          (mem_re),
    .mem_raddr_o       (mem_raddr),
    .mem_rdata_i       (mem_rdata)
  );

  // list words, position i at address i
  ils_ram #(
    .Width (WORD_BITS),
    .Depth (DEPTH)
  ) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign busy = ctrl.busy;

  // the length never passes the list capacity
  `ILS_ASSERT(a_len_bound, length_o <= PosBits'(DEPTH), "length beyond capacity")
  // a result is only shown once the sequencer is back at rest
  `ILS_ASSERT(a_done_idle, done_o |-> !busy, "result strobe while busy")
  // every accepted transaction either finishes at once or keeps the block busy
  `ILS_ASSERT(a_accept_prog, (start && !busy) |=> (done_o || busy), "command lost")
  // ram writes only happen inside a command
  `ILS_ASSERT(a_wr_in_cmd, ctrl.mem_wr |-> (busy || start), "stray ram write")
  // the length moves only together with a result
  `ILS_ASSERT(a_len_with_done, !$stable(length_o) |-> done_o, "length changed silently")

endmodule

`default_nettype wire

[sv/ils_ram.sv]
// generic single-clock ram, one write port, one registered read port
`default_nettype none

module ils_ram #(
  parameter int Width = 32,
  parameter int Depth = 64,
  localparam int AddrBits = $clog2(Depth)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrBits-1:0] waddr_i,
  input  logic [Width-1:0]    wdata_i,
  input  logic                re_i,
  input  logic [AddrBits-1:0] raddr_i,
  output logic [Width-1:0]    rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[sv/ils_seq.sv]
// command sequencer: decode, shift, scan and result registers
`default_nettype none

module ils_seq #(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 32,
  localparam int AddrBits = $clog2(DEPTH),
  localparam int PosBits  = $clog2(DEPTH + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [ils_pkg::FuncBits-1:0]      func_i,
  input  logic [WORD_BITS-1:0]              value_i,
  input  logic [PosBits-1:0]                position_i,
  output ils_pkg::ils_ctrl_t                ctrl_o,
  output logic                              done_o,
  output logic [WORD_BITS-1:0]              result_value_o,
  output logic [PosBits-1:0]                result_position_o,
  output logic [ils_pkg::StatusBits-1:0]    status_o,
  output logic [PosBits-1:0]                length_o,
  output logic                              mem_we_o,
  output logic [AddrBits-1:0]               mem_waddr_o,
  output logic [WORD_BITS-1:0]              mem_wdata_o,
  output logic                              mem_re_o,
  output logic [AddrBits-1:0]               mem_raddr_o,
  input  logic [WORD_BITS-1:0]              mem_rdata_i
);

  import ils_pkg::*;

  ils_state_e           state_q, state_d;
  logic [PosBits-1:0]   count_q, count_d;
  logic                 done_q, done_d;
  logic [AddrBits-1:0]  ptr_q, ptr_d;
  logic [AddrBits-1:0]  tgt_q, tgt_d;
  logic [WORD_BITS-1:0] word_q, word_d;
  logic [WORD_BITS-1:0] res_value_q;
  logic [PosBits-1:0]   res_pos_q;
  ils_status_e          res_status_q;

  logic                 finish;
  logic [WORD_BITS-1:0] fin_value;
  logic [PosBits-1:0]   fin_pos;
  ils_status_e          fin_status;

  ils_func_e            func;
  logic                 full, empty, pos_below, pos_le;
  logic [PosBits-1:0]   ins_pos;
  logic [PosBits-1:0]   count_m1;
  logic [AddrBits-1:0]  last_idx;
  logic [AddrBits-1:0]  ptr_inc, ptr_inc2, ptr_dec, tgt_inc;
  logic [WORD_BITS-1:0] miss_value;

  assign func       = ils_func_e'(func_i);
  assign full       = (count_q == PosBits'(DEPTH));
  assign empty      = (count_q == '0);
  assign pos_below  = (position_i < count_q);
  assign pos_le     = (position_i <= count_q);
  assign count_m1   = count_q - PosBits'(1);
  assign last_idx   = count_m1[AddrBits-1:0];
  assign ptr_inc    = ptr_q + AddrBits'(1);
  assign ptr_inc2   = ptr_q + AddrBits'(2);
  assign ptr_dec    = ptr_q - AddrBits'(1);
  assign tgt_inc    = tgt_q + AddrBits'(1);
  assign miss_value = '1;

  always_comb begin
    case (func)
      FN_ADD_FRONT: ins_pos = '0;
      FN_ADD_BACK:  ins_pos = count_q;
      default:      ins_pos = position_i;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    tgt_d       = tgt_q;
    word_d      = word_q;
    finish      = 1'b0;
    fin_value   = '0;
    fin_pos     = '0;
    fin_status  = ST_OK;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = mem_rdata_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (func)
            FN_ADD_FRONT, FN_ADD_BACK, FN_INSERT_AT: begin
              if (full) begin
                finish     = 1'b1;
                fin_status = ST_FULL;
              end else if (func == FN_INSERT_AT && !pos_le) begin
                finish     = 1'b1;
                fin_status = ST_MISS;
                fin_value  = miss_value;
              end else if (ins_pos == count_q) begin
                // append: nothing above to move
                mem_we_o    = 1'b1;
                mem_waddr_o = ins_pos[AddrBits-1:0];
                mem_wdata_o = value_i;
                count_d     = count_q + PosBits'(1);
                finish      = 1'b1;
              end else begin
                tgt_d       = ins_pos[AddrBits-1:0];
                word_d      = value_i;
                mem_re_o    = 1'b1;
                mem_raddr_o = last_idx;
                ptr_d       = last_idx;
                state_d     = S_SHIFT_UP;
              end
            end
            FN_REMOVE_FRONT, FN_REMOVE_BACK, FN_REMOVE_AT: begin
              if (empty || (func == FN_REMOVE_AT && !pos_below)) begin
                finish     = 1'b1;
                fin_status = ST_MISS;
                fin_value  = miss_value;
              end else begin
                if (func == FN_REMOVE_FRONT) begin
                  tgt_d = '0;
                end else if (func == FN_REMOVE_BACK) begin
                  tgt_d = last_idx;
                end else begin
                  tgt_d = position_i[AddrBits-1:0];
                end
                mem_re_o    = 1'b1;
                mem_raddr_o = tgt_d;
                state_d     = S_RM_HEAD;
              end
            end
            FN_GET_AT: begin
              if (!pos_below) begin
                finish     = 1'b1;
                fin_status = ST_MISS;
                fin_value  = miss_value;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = position_i[AddrBits-1:0];
                state_d     = S_GET_WAIT;
              end
            end
            FN_FIND: begin
              if (empty) begin
                finish     = 1'b1;
                fin_status = ST_MISS;
                fin_value  = miss_value;
              end else begin
                word_d      = value_i;
                mem_re_o    = 1'b1;
                mem_raddr_o = '0;
                ptr_d       = '0;
                state_d     = S_SCAN;
              end
            end
            default: begin
              finish     = 1'b1;
              fin_status = ST_MISS;
              fin_value  = miss_value;
            end
          endcase
        end
      end

      // data of entry ptr moves up one place, next lower entry is fetched unless ptr is the target
      S_SHIFT_UP: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = ptr_inc;
        mem_wdata_o = mem_rdata_i;
        if (ptr_q == tgt_q) begin
          state_d = S_INS_LAST;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = ptr_dec;
          ptr_d       = ptr_dec;
        end
      end

      S_INS_LAST: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = tgt_q;
        mem_wdata_o = word_q;
        count_d     = count_q + PosBits'(1);
        finish      = 1'b1;
      end

      // removed word arrives; start pulling the tail down if there is one
      S_RM_HEAD: begin
        word_d = mem_rdata_i;
        if (tgt_q == last_idx) begin
          count_d   = count_m1;
          finish    = 1'b1;
          fin_value = mem_rdata_i;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = tgt_inc;
          ptr_d       = tgt_q;
          state_d     = S_SHIFT_DN;
        end
      end

      S_SHIFT_DN: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = ptr_q;
        mem_wdata_o = mem_rdata_i;
        if (ptr_inc == last_idx) begin
          count_d   = count_m1;
          finish    = 1'b1;
          fin_value = word_q;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = ptr_inc2;
          ptr_d       = ptr_inc;
        end
      end

      S_GET_WAIT: begin
        finish    = 1'b1;
        fin_value = mem_rdata_i;
      end

      S_SCAN: begin
        if (mem_rdata_i == word_q) begin
          finish    = 1'b1;
          fin_value = mem_rdata_i;
          fin_pos   = PosBits'(ptr_q);
        end else if (ptr_q == last_idx) begin
          finish     = 1'b1;
          fin_status = ST_MISS;
          fin_value  = miss_value;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = ptr_inc;
          ptr_d       = ptr_inc;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    done_d = finish;
    if (finish) begin
      state_d = S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q  <= ptr_d;
    tgt_q  <= tgt_d;
    word_q <= word_d;
    if (finish) begin
      res_value_q  <= fin_value;
      res_pos_q    <= fin_pos;
      res_status_q <= fin_status;
    end
  end

  assign ctrl_o.busy       = (state_q != S_IDLE);
  assign ctrl_o.mem_wr     = mem_we_o;
  assign done_o            = done_q;
  assign result_value_o    = res_value_q;
  assign result_position_o = res_pos_q;
  assign status_o          = res_status_q;
  assign length_o          = count_q;

endmodule

`default_nettype wire

[tb/tb_indexed_list_store.sv]
// self-checking testbench for the indexed list store: directed table, fill to full, random phases
module tb_indexed_list_store;
  import ils_pkg::*;

  localparam int Depth        = DepthDef;
  localparam int WordW        = WordBitsDef;
  localparam int PosW         = $clog2(Depth + 1);
  localparam int CycleLimit   = 1_000_000;
  localparam int RandPerPhase = 365;
  // longest command is an insert at the front of a nearly full list
  localparam int SettleCycles = Depth + 4;
  // random commands per stretch before the fill/drain bias flips
  localparam int SwingLen     = 130;
  localparam int NoisePct     = 8;

  localparam logic [WordW-1:0] NegOne  = '1;
  localparam logic [WordW-1:0] MaxWord = {1'b0, {(WordW-1){1'b1}}};
  localparam logic [WordW-1:0] MinWord = {1'b1, {(WordW-1){1'b0}}};

  // one reply of the block, as the predictor sees it
  typedef struct {
    logic [WordW-1:0] value;
    logic [PosW-1:0]  position;
    ils_status_e      status;
    logic [PosW-1:0]  length;
  } list_reply_t;

  // one command transaction; fixed marks a reply typed in by hand
  typedef struct {
    ils_func_e        op;
    logic [WordW-1:0] value;
    logic [PosW-1:0]  position;
    bit               fixed;
    list_reply_t      reply;
  } list_cmd_t;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  start      = 1'b0;
  logic                  busy;
  logic [FuncBits-1:0]   func_i     = '0;
  logic [WordW-1:0]      value_i    = '0;
  logic [PosW-1:0]       position_i = '0;
  logic                  done_o;
  logic [WordW-1:0]      result_value_o;
  logic [PosW-1:0]       result_position_o;
  logic [StatusBits-1:0] status_o;
  logic [PosW-1:0]       length_o;

  // shadow copy of the list contents and length
  logic [WordW-1:0] shadow_words [Depth];
  int               shadow_len = 0;
  int               peak_len   = 0;

  // replies still owed by the block, oldest first
  list_reply_t      expected_replies [$];
  list_reply_t      want;
  list_cmd_t        directed_rows [$];

  int err_count    = 0;
  int sent_count   = 0;
  int result_count = 0;
  int status_seen [4] = '{0, 0, 0, 0};
  // sender idle percentage per random phase; the third phase stands for the
  // receiver-stall setting, which has no effect since done_o cannot be held off
  int idle_plan [4] = '{0, 66, 0, 27};

  indexed_list_store u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .func_i            (func_i),
    .value_i           (value_i),
    .position_i        (position_i),
    .done_o            (done_o),
    .result_value_o    (result_value_o),
    .result_position_o (result_position_o),
    .status_o          (status_o),
    .length_o          (length_o)
  );

  always #2 clk_i = ~clk_i;

  // predictor: applies one command to the shadow list and returns its reply
  function automatic list_reply_t apply_list_cmd(ils_func_e op, logic [WordW-1:0] v, int p);
    list_reply_t r;
    int          at;
    int          i;
    bit          hit;
    r.value    = '0;
    r.position = '0;
    r.status   = ST_OK;
    hit        = 1'b0;
    case (op)
      FN_ADD_FRONT, FN_ADD_BACK, FN_INSERT_AT: begin
        at = (op == FN_ADD_FRONT) ? 0 : (op == FN_ADD_BACK) ? shadow_len : p;
        // a full list refuses before the position is looked at
        if (shadow_len >= Depth) begin
          r.status = ST_FULL;
        end else if (at > shadow_len) begin
          r.status = ST_MISS;
          r.value  = NegOne;
        end else begin
          for (i = shadow_len; i > at; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[at] = v;
          shadow_len++;
        end
      end
      FN_REMOVE_FRONT, FN_REMOVE_BACK, FN_REMOVE_AT: begin
        at = (op == FN_REMOVE_FRONT) ? 0 : (op == FN_REMOVE_BACK) ? shadow_len - 1 : p;
        if (shadow_len == 0 || at >= shadow_len) begin
          r.status = ST_MISS;
          r.value  = NegOne;
        end else begin
          r.value = shadow_words[at];
          for (i = at; i + 1 < shadow_len; i++) shadow_words[i] = shadow_words[i+1];
          shadow_len--;
        end
      end
      FN_GET_AT: begin
        if (p >= shadow_len) begin
          r.status = ST_MISS;
          r.value  = NegOne;
        end else begin
          r.value = shadow_words[p];
        end
      end
      default: begin
        // find: first matching position wins
        for (i = 0; i < shadow_len && !hit; i++) begin
          if (shadow_words[i] == v) begin
            hit        = 1'b1;
            r.value    = v;
            r.position = PosW'(i);
          end
        end
        if (!hit) begin
          r.status = ST_MISS;
          r.value  = NegOne;
        end
      end
    endcase
    r.length = PosW'(shadow_len);
    return r;
  endfunction

  function automatic list_cmd_t cmd_row(ils_func_e op, logic [WordW-1:0] v, int p);
    list_cmd_t c;
    c.op             = op;
    c.value          = v;
    c.position       = PosW'(p);
    c.fixed          = 1'b0;
    c.reply.value    = '0;
    c.reply.position = '0;
    c.reply.status   = ST_OK;
    c.reply.length   = '0;
    return c;
  endfunction

  function automatic list_cmd_t cmd_row_exp(ils_func_e op, logic [WordW-1:0] v, int p,
                                            logic [WordW-1:0] rv, int rp, ils_status_e st,
                                            int len);
    list_cmd_t c;
    c                = cmd_row(op, v, p);
    c.fixed          = 1'b1;
    c.reply.value    = rv;
    c.reply.position = PosW'(rp);
    c.reply.status   = st;
    c.reply.length   = PosW'(len);
    return c;
  endfunction

  // word mix: extremes, a small pool that makes duplicates, and full random
  function automatic logic [WordW-1:0] pick_word();
    case ($urandom_range(7))
      0:       return MaxWord;
      1:       return MinWord;
      2, 3:    return WordW'($urandom_range(3)) - 1'b1;
      default: return $urandom;
    endcase
  endfunction

  // mostly well-formed commands at legal positions, grow_pct steers the length
  function automatic list_cmd_t random_cmd(int grow_pct);
    list_cmd_t c;
    int        roll;
    int        top;
    roll = $urandom_range(99);
    top  = (shadow_len > 0) ? shadow_len - 1 : 0;
    c    = cmd_row(FN_FIND, pick_word(), $urandom_range(Depth));
    if (roll < NoisePct) begin
      // noise: any command, any position from 0 to Depth
      c.op = ils_func_e'($urandom_range(7));
    end else if (roll < NoisePct + ((100 - NoisePct) * grow_pct) / 100) begin
      c.op       = ils_func_e'(FN_ADD_FRONT + $urandom_range(2));
      c.position = PosW'($urandom_range(shadow_len));
    end else if ($urandom_range(99) < 60) begin
      c.op       = ils_func_e'(FN_REMOVE_FRONT + $urandom_range(2));
      c.position = PosW'($urandom_range(top));
    end else if ($urandom_range(1) == 1) begin
      c.op       = FN_GET_AT;
      c.position = PosW'($urandom_range(top));
    end else if (shadow_len > 0 && $urandom_range(9) < 7) begin
      // find a word that is in the list
      c.value = shadow_words[$urandom_range(top)];
    end
    return c;
  endfunction

  task automatic check_field(input string name, input logic [WordW-1:0] exp_val,
                             input logic [WordW-1:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_val, act_val);
      err_count++;
    end
  endtask

  // drive one command transaction; the prediction is made at the accepting edge
  task automatic send_cmd(input list_cmd_t c, input int idle_pct);
    list_reply_t r;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start      <= 1'b1;
    func_i     <= c.op;
    value_i    <= c.value;
    position_i <= c.position;
    // start is high from here on, so the first edge with busy low takes it
    do @(posedge clk_i); while (busy);
    r = apply_list_cmd(c.op, c.value, c.position);
    expected_replies.push_back(c.fixed ? c.reply : r);
    sent_count++;
    if (shadow_len > peak_len) peak_len = shadow_len;
  endtask

  task automatic drain_replies();
    start <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk_i);
  endtask

  // result side: done_o marks a one-cycle reply that is taken at the next edge
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_replies.size() == 0) begin
        $error("result with no command outstanding");
        err_count++;
      end else begin
        want = expected_replies.pop_front();
        check_field("result_value", want.value, result_value_o);
        check_field("result_position", want.position, result_position_o);
        check_field("status", want.status, status_o);
        check_field("length", want.length, length_o);
        result_count++;
        status_seen[status_o]++;
      end
    end
  end

  // watchdog
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d replies outstanding", CycleLimit,
             expected_replies.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int ph;
    int k;
    int grow;
    int rand_count;
    int directed_count;
    rand_count = 0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list: every removal and read misses, bad insert position misses,
    // then build a short list with extremes and alternating bit patterns
    directed_rows.push_back(cmd_row_exp(FN_REMOVE_FRONT, '0, 0, NegOne, 0, ST_MISS, 0));
    directed_rows.push_back(cmd_row_exp(FN_REMOVE_BACK, '0, 0, NegOne, 0, ST_MISS, 0));
    directed_rows.push_back(cmd_row_exp(FN_REMOVE_AT, '0, 0, NegOne, 0, ST_MISS, 0));
    directed_rows.push_back(cmd_row_exp(FN_GET_AT, '0, 0, NegOne, 0, ST_MISS, 0));
    directed_rows.push_back(cmd_row_exp(FN_FIND, NegOne, 0, NegOne, 0, ST_MISS, 0));
    directed_rows.push_back(cmd_row_exp(FN_INSERT_AT, MaxWord, 1, NegOne, 0, ST_MISS, 0));
    directed_rows.push_back(cmd_row_exp(FN_INSERT_AT, MaxWord, 0, '0, 0, ST_OK, 1));
    directed_rows.push_back(cmd_row_exp(FN_ADD_FRONT, MinWord, 0, '0, 0, ST_OK, 2));
    directed_rows.push_back(cmd_row_exp(FN_ADD_BACK, NegOne, 0, '0, 0, ST_OK, 3));
    directed_rows.push_back(cmd_row_exp(FN_ADD_BACK, '0, 0, '0, 0, ST_OK, 4));
    directed_rows.push_back(cmd_row_exp(FN_INSERT_AT, 32'h5555_5555, 2, '0, 0, ST_OK, 5));
    // position equal to the length appends
    directed_rows.push_back(cmd_row_exp(FN_INSERT_AT, 32'hAAAA_AAAA, 5, '0, 0, ST_OK, 6));
    directed_rows.push_back(cmd_row_exp(FN_INSERT_AT, 32'h1, Depth, NegOne, 0, ST_MISS, 6));
    directed_rows.push_back(cmd_row_exp(FN_GET_AT, '0, Depth, NegOne, 0, ST_MISS, 6));
    directed_rows.push_back(cmd_row(FN_GET_AT, '0, 0));
    directed_rows.push_back(cmd_row(FN_FIND, NegOne, 0));
    directed_rows.push_back(cmd_row_exp(FN_FIND, 32'h1234_5678, 0, NegOne, 0, ST_MISS, 6));
    directed_rows.push_back(cmd_row_exp(FN_REMOVE_AT, '0, 6, NegOne, 0, ST_MISS, 6));
    directed_rows.push_back(cmd_row(FN_REMOVE_AT, '0, 2));
    directed_rows.push_back(cmd_row(FN_REMOVE_BACK, '0, 0));
    directed_rows.push_back(cmd_row(FN_REMOVE_FRONT, '0, 0));
    directed_rows.push_back(cmd_row(FN_FIND, '0, 0));
    // removal at the tail, then back removals down to the single-entry case
    directed_rows.push_back(cmd_row(FN_REMOVE_AT, '0, 2));
    directed_rows.push_back(cmd_row(FN_REMOVE_BACK, '0, 0));
    directed_rows.push_back(cmd_row(FN_REMOVE_BACK, '0, 0));
    foreach (directed_rows[i]) send_cmd(directed_rows[i], 0);

    // fill to capacity so the full refusals and the longest shifts are hit
    while (shadow_len < Depth) send_cmd(cmd_row(FN_ADD_BACK, pick_word(), 0), 0);
    directed_rows.delete();
    directed_rows.push_back(cmd_row_exp(FN_ADD_FRONT, '0, 0, '0, 0, ST_FULL, Depth));
    directed_rows.push_back(cmd_row_exp(FN_ADD_BACK, '0, 0, '0, 0, ST_FULL, Depth));
    // full is reported even for a position that would otherwise append
    directed_rows.push_back(cmd_row_exp(FN_INSERT_AT, '0, Depth, '0, 0, ST_FULL, Depth));
    directed_rows.push_back(cmd_row_exp(FN_INSERT_AT, NegOne, 0, '0, 0, ST_FULL, Depth));
    directed_rows.push_back(cmd_row(FN_GET_AT, '0, Depth - 1));
    directed_rows.push_back(cmd_row(FN_FIND, shadow_words[Depth-1], 0));
    directed_rows.push_back(cmd_row(FN_REMOVE_AT, '0, 0));
    directed_rows.push_back(cmd_row(FN_INSERT_AT, MinWord, 0));
    directed_rows.push_back(cmd_row(FN_REMOVE_BACK, '0, 0));
    foreach (directed_rows[i]) send_cmd(directed_rows[i], 0);
    directed_count = sent_count;

    // random phases; the bias swings between filling and draining so the
    // length sweeps from empty to full; each phase ends by draining the owed replies
    for (ph = 0; ph < 4; ph++) begin
      for (k = 0; k < RandPerPhase; k++) begin
        grow = ((rand_count / SwingLen) % 2 == 0) ? 70 : 5;
        send_cmd(random_cmd(grow), idle_plan[ph]);
        rand_count++;
      end
      drain_replies();
    end

    repeat (SettleCycles) @(posedge clk_i);

    $display("sent %0d commands (%0d directed), checked %0d results: %0d ok, %0d miss, %0d full",
             sent_count, directed_count, result_count, status_seen[ST_OK],
             status_seen[ST_MISS], status_seen[ST_FULL]);
    $display("list length peaked at %0d of %0d; sender idle of 0, 66 and 27 percent",
             peak_len, Depth);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
